// File: sv/msb_pkg.sv
// ============================================================================
// msb_pkg
// Shared types and constants of the sorted-block compare-split unit.
// ============================================================================
package msb_pkg;

   localparam int BLOCK_SIZE_DEFAULT = 32;   // pairs held per block
   localparam int VALUE_W            = 32;   // element width
   localparam int POS_W              = 6;    // result position and address carrier width
   localparam int REQ_DATA_W         = 64;   // local_value, partner_value
   localparam int RSP_DATA_W         = 40;   // kept_value, position, zero fill

   // Write and read requests from the sequencer to the block store.
   typedef struct packed {
      logic               wr_en;
      logic [POS_W-1:0]   wr_addr;
      logic [VALUE_W-1:0] wr_own;
      logic [VALUE_W-1:0] wr_partner;
      logic [POS_W-1:0]   own_rd_addr;
      logic [POS_W-1:0]   partner_rd_addr;
   } store_req_type;

   // One merged element on its way to the output register.
   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
      logic               overflow;
      logic               last;
   } merge_result_type;

endpackage

// File: sv/msb_store.sv
// ============================================================================
// msb_store
// Two synchronous memories holding the own and the partner block, one write
// port shared by both and one registered read port each.
// ============================================================================
module msb_store #(
   parameter int BLOCK_SIZE = msb_pkg::BLOCK_SIZE_DEFAULT
) (
   input  logic                         clock,
   input  msb_pkg::store_req_type       store_req,
   output logic [msb_pkg::VALUE_W-1:0]  own_rd_data,
   output logic [msb_pkg::VALUE_W-1:0]  partner_rd_data
);

   localparam int IDX_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

   logic [msb_pkg::VALUE_W-1:0] own_mem     [BLOCK_SIZE];
   logic [msb_pkg::VALUE_W-1:0] partner_mem [BLOCK_SIZE];

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         own_mem[store_req.wr_addr[IDX_W-1:0]]     <= store_req.wr_own;
         partner_mem[store_req.wr_addr[IDX_W-1:0]] <= store_req.wr_partner;
      end
      own_rd_data     <= own_mem[store_req.own_rd_addr[IDX_W-1:0]];
      partner_rd_data <= partner_mem[store_req.partner_rd_addr[IDX_W-1:0]];
   end

endmodule

// File: sv/msb_merge.sv
// ============================================================================
// msb_merge
// Load and merge sequencer: stores incoming pairs, then walks both blocks
// through the store and picks one kept element per cycle when out_free.
// ============================================================================
module msb_merge #(
   parameter int BLOCK_SIZE = msb_pkg::BLOCK_SIZE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [msb_pkg::VALUE_W-1:0]   local_value,
   input  logic [msb_pkg::VALUE_W-1:0]   partner_value,
   input  logic                          keep_small,
   input  logic                          last_pair,
   input  logic [msb_pkg::VALUE_W-1:0]   own_rd_data,
   input  logic [msb_pkg::VALUE_W-1:0]   partner_rd_data,
   input  logic                          out_free,
   output msb_pkg::store_req_type        store_req,
   output msb_pkg::merge_result_type     result
);

   localparam int IDX_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
   localparam int CNT_W = $clog2(BLOCK_SIZE + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PRIME,
      ST_MERGE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               merge_ovf_ff, merge_ovf_in;
   logic               small_ff, small_in;
   logic [IDX_W-1:0]   own_idx_ff, own_idx_in;
   logic [IDX_W-1:0]   par_idx_ff, par_idx_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   steps_ff, steps_in;

   logic               accept;
   logic               full;
   logic [CNT_W-1:0]   block_len;
   logic [IDX_W-1:0]   top_idx;
   logic               own_less;
   logic               take_own;
   logic               step_last;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(BLOCK_SIZE));
   assign block_len = full ? count_ff : count_ff + CNT_W'(1);
   assign top_idx   = IDX_W'(block_len - CNT_W'(1));

   // Both walks stop after n picks, so neither index runs past its block.
   assign own_less  = $signed(own_rd_data) < $signed(partner_rd_data);
   assign take_own  = small_ff ? own_less : !own_less;
   assign step_last = (steps_ff == '0);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      merge_ovf_in = merge_ovf_ff;
      small_in     = small_ff;
      own_idx_in   = own_idx_ff;
      par_idx_in   = par_idx_ff;
      pos_in       = pos_ff;
      steps_in     = steps_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (last_pair) begin
                  merge_ovf_in = ovf_ff || full;
                  small_in     = keep_small;
                  own_idx_in   = keep_small ? '0 : top_idx;
                  par_idx_in   = keep_small ? '0 : top_idx;
                  pos_in       = keep_small ? '0 : top_idx;
                  steps_in     = top_idx;
                  count_in     = '0;
                  ovf_in       = 1'b0;
                  state_in     = ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            // Re-issues the first reads after the last pair has been written.
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (out_free) begin
               if (small_ff) begin
                  if (take_own) begin
                     own_idx_in = own_idx_ff + IDX_W'(1);
                  end else begin
                     par_idx_in = par_idx_ff + IDX_W'(1);
                  end
                  pos_in = pos_ff + IDX_W'(1);
               end else begin
                  if (take_own) begin
                     own_idx_in = own_idx_ff - IDX_W'(1);
                  end else begin
                     par_idx_in = par_idx_ff - IDX_W'(1);
                  end
                  pos_in = pos_ff - IDX_W'(1);
               end
               steps_in = steps_ff - IDX_W'(1);
               if (step_last) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
      merge_ovf_ff <= merge_ovf_in;
      small_ff     <= small_in;
      own_idx_ff   <= own_idx_in;
      par_idx_ff   <= par_idx_in;
      pos_ff       <= pos_in;
      steps_ff     <= steps_in;
   end

   // The read addresses follow the next index values, so the read data of
   // each cycle matches the index registers.
   always_comb begin
      store_req.wr_en           = accept && !full;
      store_req.wr_addr         = msb_pkg::POS_W'(count_ff);
      store_req.wr_own          = local_value;
      store_req.wr_partner      = partner_value;
      store_req.own_rd_addr     = msb_pkg::POS_W'(own_idx_in);
      store_req.partner_rd_addr = msb_pkg::POS_W'(par_idx_in);
   end

   always_comb begin
      result.valid    = (state_ff == ST_MERGE);
      result.value    = take_own ? own_rd_data : partner_rd_data;
      result.position = msb_pkg::POS_W'(pos_ff);
      result.overflow = merge_ovf_ff;
      result.last     = step_last;
   end

endmodule

// File: sv/merge_split_sorted_blocks_unit.sv
// ============================================================================
// merge_split_sorted_blocks_unit
// Compare-split step of odd-even transposition sort over two sorted blocks.
// ============================================================================
//
//   Channel   Direction  tdata (low bit up)                   tuser           tlast
//   req_      in         local_value, partner_value           keep_small      last_pair
//   rsp_      out        kept_value, position, 2 zero bits    block_overflow  last_result
//
// Request transactions are taken back to back while a block loads. The
// transaction carrying last_pair is followed by a store read setup state
// (ST_PRIME) and then one response per cycle unless rsp_tready stalls it,
// n responses for an n-pair block, set by the single read port of each
// block memory. Requests are held off during the merge.
// Reset clears the sequencer and the output register; the memories are
// not cleared, since only entries of the current block are read.
// A stalled response holds the merge while the pending result waits in the
// output register; only the last result of a block can wait while the next block loads.
//
module merge_split_sorted_blocks_unit #(
   parameter int BLOCK_SIZE = msb_pkg::BLOCK_SIZE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [msb_pkg::REQ_DATA_W-1:0]  req_tdata,   // local_value, partner_value
   input  logic                            req_tuser,   // keep_small
   input  logic                            req_tlast,   // last_pair
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [msb_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // kept_value, position, zero fill
   output logic                            rsp_tuser,   // block_overflow
   output logic                            rsp_tlast    // last_result
);

   localparam int VW = msb_pkg::VALUE_W;
   localparam int PW = msb_pkg::POS_W;

   msb_pkg::store_req_type    store_req;
   msb_pkg::merge_result_type result;
   logic [VW-1:0]             own_rd_data;
   logic [VW-1:0]             partner_rd_data;
   logic                      out_free;

   // Output register state.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]             rsp_value_ff;
   logic [PW-1:0]             rsp_pos_ff;
   logic                      rsp_ovf_ff;
   logic                      rsp_last_ff;

   msb_store #(
      .BLOCK_SIZE (BLOCK_SIZE)
   ) u_store (
      .clock           (clock),
      .store_req       (store_req),
      .own_rd_data     (own_rd_data),
      .partner_rd_data (partner_rd_data)
   );

   msb_merge #(
      .BLOCK_SIZE (BLOCK_SIZE)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .local_value     (req_tdata[VW-1:0]),
      .partner_value   (req_tdata[2*VW-1:VW]),
      .keep_small      (req_tuser),
      .last_pair       (req_tlast),
      .own_rd_data     (own_rd_data),
      .partner_rd_data (partner_rd_data),
      .out_free        (out_free),
      .store_req       (store_req),
      .result          (result)
   );

   // The output register takes a new result when it is empty or its
   // current transaction completes in this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_free && result.valid) begin
         rsp_value_ff <= result.value;
         rsp_pos_ff   <= result.position;
         rsp_ovf_ff   <= result.overflow;
         rsp_last_ff  <= result.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(msb_pkg::RSP_DATA_W - VW - PW){1'b0}}, rsp_pos_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
